@@ rtl/mwa_pkg.sv @@
// ----------------------------------------------------------------------------
// mwa_pkg
// Shared constants, register indexes and types of the moisture window
// averager.
// ----------------------------------------------------------------------------
package mwa_pkg;

    // Window and sample geometry.
    localparam int WINDOW      = 60;
    localparam int SAMPLE_BITS = 12;
    localparam int SAMPLE_W    = 12;
    localparam int CNT_W       = $clog2(WINDOW + 1);

    // Field widths.
    localparam int LEVEL_W   = 12;
    localparam int MINPCT_W  = 7;
    localparam int SUM_W     = 18;
    localparam int OFFCNT_W  = 6;
    localparam int AVG_W     = 13;
    localparam int PCT_W     = 8;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << SAMPLE_BITS) - 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_DRY_LEVEL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WET_LEVEL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_MARGIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_MARGIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PERCENT = 3'd4;

    localparam logic [LEVEL_W-1:0]  DRY_RESET    = 12'd2100;
    localparam logic [LEVEL_W-1:0]  WET_RESET    = 12'd1150;
    localparam logic [LEVEL_W-1:0]  HIGH_RESET   = 12'd500;
    localparam logic [LEVEL_W-1:0]  LOW_RESET    = 12'd2000;
    localparam logic [MINPCT_W-1:0] MINPCT_RESET = 7'd30;

    // Percentage scaling.
    localparam logic signed [19:0] PCT_SCALE = 20'sd100;
    localparam logic [6:0]         PCT_MAX   = 7'd100;

    // Shared restoring divider.
    localparam int DIV_N_W   = 19;
    localparam int DIV_D_W   = 12;
    localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

    // Job queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One finished window handed from the front to the back.
    typedef struct packed {
        logic [SUM_W-1:0]    valid_sum;
        logic [CNT_W-1:0]    valid_cnt;
        logic [OFFCNT_W-1:0] off_cnt;
        logic [SUM_W-1:0]    off_sum;
        logic [LEVEL_W-1:0]  dry;
        logic [LEVEL_W-1:0]  wet;
        logic [MINPCT_W-1:0] min_pct;
    } job_t;

    // Divider request and response.
    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quotient;
    } div_rsp_t;

endpackage

@@ rtl/mwa_if.sv @@
// ----------------------------------------------------------------------------
// mwa_if
// Valid/ready channels of the moisture window averager: one for samples,
// one for window results.
// ----------------------------------------------------------------------------
interface mwa_sample_if;
    logic        valid;
    logic        ready;
    logic [11:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface mwa_result_if;
    logic               valid;
    logic               ready;
    logic signed [12:0] average;
    logic signed [7:0]  percent;
    logic [5:0]         offscale_count;
    logic [17:0]        offscale_sum;
    logic               low_moisture;
    logic               no_valid;
    logic               calib_error;

    modport source (output valid, output average, output percent, output offscale_count,
                    output offscale_sum, output low_moisture, output no_valid,
                    output calib_error, input ready);
    modport sink   (input valid, input average, input percent, input offscale_count,
                    input offscale_sum, input low_moisture, input no_valid,
                    input calib_error, output ready);
endinterface

@@ rtl/mwa_front.sv @@
// ----------------------------------------------------------------------------
// mwa_front
// Holds the configuration registers, classifies each sample as off-scale or
// valid, accumulates the window and pushes a job at the end of each window.
// ----------------------------------------------------------------------------
module mwa_front
    import mwa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    mwa_sample_if.sink            sample_in,
    output logic                  push_valid,
    input  logic                  push_ready,
    output job_t                  push_job
);

    logic [LEVEL_W-1:0]  dry_reg;
    logic [LEVEL_W-1:0]  wet_reg;
    logic [LEVEL_W-1:0]  high_reg;
    logic [LEVEL_W-1:0]  low_reg;
    logic [MINPCT_W-1:0] min_pct_reg;

    logic [SUM_W-1:0]    valid_sum_reg;
    logic [SUM_W-1:0]    valid_sum_next;
    logic [SUM_W-1:0]    off_sum_reg;
    logic [SUM_W-1:0]    off_sum_next;
    logic [CNT_W-1:0]    off_cnt_reg;
    logic [CNT_W-1:0]    off_cnt_next;
    logic [CNT_W-1:0]    index_reg;

    logic [SAMPLE_W-1:0]  s;
    logic [LEVEL_W:0]     hi_lim;
    logic signed [13:0]   lo_lim;
    logic                 reject;
    logic [LEVEL_W-1:0]   clamp_val;
    logic                 last;
    logic                 accept;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dry_reg     <= DRY_RESET;
            wet_reg     <= WET_RESET;
            high_reg    <= HIGH_RESET;
            low_reg     <= LOW_RESET;
            min_pct_reg <= MINPCT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DRY_LEVEL:   dry_reg     <= cfg_data[LEVEL_W-1:0];
                REG_WET_LEVEL:   wet_reg     <= cfg_data[LEVEL_W-1:0];
                REG_HIGH_MARGIN: high_reg    <= cfg_data[LEVEL_W-1:0];
                REG_LOW_MARGIN:  low_reg     <= cfg_data[LEVEL_W-1:0];
                REG_MIN_PERCENT: min_pct_reg <= cfg_data[MINPCT_W-1:0];
                default: ;
            endcase
        end
    end

    // Classify the sample and clamp valid ones to the calibration range.
    always_comb
    begin
        s         = sample_in.sample & SAMPLE_MASK;
        hi_lim    = {1'b0, dry_reg} + {1'b0, high_reg};
        lo_lim    = $signed({2'b00, wet_reg}) - $signed({2'b00, low_reg});
        reject    = ({1'b0, s} > hi_lim) || ($signed({2'b00, s}) < lo_lim);
        if (s < wet_reg)
            clamp_val = wet_reg;
        else if (s > dry_reg)
            clamp_val = dry_reg;
        else
            clamp_val = s;

        valid_sum_next = reject ? valid_sum_reg : valid_sum_reg + SUM_W'(clamp_val);
        off_sum_next   = reject ? off_sum_reg + SUM_W'(s) : off_sum_reg;
        off_cnt_next   = reject ? off_cnt_reg + CNT_W'(1) : off_cnt_reg;
        last           = (index_reg == CNT_W'(WINDOW - 1));
    end

    // A sample is taken whenever the queue has room for a possible job.
    assign sample_in.ready = push_ready;
    assign accept          = sample_in.valid && push_ready;
    assign push_valid      = accept && last;

    always_comb
    begin
        push_job.valid_sum = valid_sum_next;
        push_job.valid_cnt = CNT_W'(WINDOW) - off_cnt_next;
        push_job.off_cnt   = OFFCNT_W'(off_cnt_next);
        push_job.off_sum   = off_sum_next;
        push_job.dry       = dry_reg;
        push_job.wet       = wet_reg;
        push_job.min_pct   = min_pct_reg;
    end

    // Window accumulators.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_sum_reg <= '0;
            off_sum_reg   <= '0;
            off_cnt_reg   <= '0;
            index_reg     <= '0;
        end
        else if (accept)
        begin
            if (last)
            begin
                valid_sum_reg <= '0;
                off_sum_reg   <= '0;
                off_cnt_reg   <= '0;
                index_reg     <= '0;
            end
            else
            begin
                valid_sum_reg <= valid_sum_next;
                off_sum_reg   <= off_sum_next;
                off_cnt_reg   <= off_cnt_next;
                index_reg     <= index_reg + CNT_W'(1);
            end
        end
    end

endmodule

@@ rtl/mwa_queue.sv @@
// ----------------------------------------------------------------------------
// mwa_queue
// Short FIFO of finished windows between the front and the back.
// ----------------------------------------------------------------------------
module mwa_queue
    import mwa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_job
);

    job_t              entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entries[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            entries[wr_ptr_reg] <= push_job;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + QPTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

endmodule

@@ rtl/mwa_div.sv @@
// ----------------------------------------------------------------------------
// mwa_div
// Unsigned restoring divider, one quotient bit per cycle. Shared by the
// average and the percentage computations.
// ----------------------------------------------------------------------------
module mwa_div
    import mwa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_N_W-1:0]   quo_reg;
    logic [DIV_D_W-1:0]   dsr_reg;
    logic [DIV_CNT_W-1:0] count_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIV_D_W:0]     rem_shift;
    logic [DIV_D_W+1:0]   diff;
    logic                 ge;

    // One restoring step.
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DIV_N_W-1]};
        diff      = {1'b0, rem_shift} - {2'b00, dsr_reg};
        ge        = !diff[DIV_D_W+1];
    end

    // Data path.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DIV_D_W-1:0] : rem_shift[DIV_D_W-1:0];
            quo_reg <= {quo_reg[DIV_N_W-2:0], ge};
        end
    end

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (count_reg == DIV_CNT_W'(1));
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= DIV_CNT_W'(DIV_N_W);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - DIV_CNT_W'(1);
                if (count_reg == DIV_CNT_W'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ rtl/mwa_back.sv @@
// ----------------------------------------------------------------------------
// mwa_back
// Takes one finished window at a time, divides out the average, maps it to a
// percentage and loads the result register.
// ----------------------------------------------------------------------------
module mwa_back
    import mwa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  job_t        pop_job,
    mwa_result_if.source result_out
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_AVG    = 3'd1;
    localparam logic [2:0] ST_MUL    = 3'd2;
    localparam logic [2:0] ST_PCT_GO = 3'd3;
    localparam logic [2:0] ST_PCT    = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0]                state_reg;
    logic [2:0]                state_next;
    job_t                      job_reg;
    logic                      none_reg;
    logic signed [AVG_W-1:0]   avg_reg;
    logic signed [PCT_W-1:0]   pct_reg;
    logic [DIV_N_W-1:0]        num_mag_reg;
    logic [DIV_D_W-1:0]        den_mag_reg;
    logic                      neg_reg;

    logic                      out_valid_reg;
    logic signed [AVG_W-1:0]   out_avg_reg;
    logic signed [PCT_W-1:0]   out_pct_reg;
    logic [OFFCNT_W-1:0]       out_off_cnt_reg;
    logic [SUM_W-1:0]          out_off_sum_reg;
    logic                      out_low_reg;
    logic                      out_none_reg;
    logic                      out_calib_reg;

    div_req_t                  div_req;
    div_rsp_t                  div_rsp;

    logic                      take;
    logic                      calib;
    logic                      load_out;
    logic signed [AVG_W-1:0]   delta;
    logic signed [19:0]        prod;
    logic signed [AVG_W-1:0]   den;

    mwa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign pop_ready = (state_reg == ST_IDLE);
    assign take      = pop_valid && pop_ready;
    assign calib     = (job_reg.dry == job_reg.wet);
    assign load_out  = (state_reg == ST_DONE) && (!out_valid_reg || result_out.ready);

    // Scaled distance from the dry level and the calibration span.
    always_comb
    begin
        delta = $signed({1'b0, avg_reg[LEVEL_W-1:0]}) - $signed({1'b0, job_reg.dry});
        prod  = 20'($signed({{7{delta[AVG_W-1]}}, delta}) * PCT_SCALE);
        den   = $signed({1'b0, job_reg.wet}) - $signed({1'b0, job_reg.dry});
    end

    // Divider requests: the average first, then the percentage.
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = {1'b0, pop_job.valid_sum};
        div_req.divisor  = DIV_D_W'(pop_job.valid_cnt);
        if (state_reg == ST_IDLE)
        begin
            div_req.start = take && (pop_job.valid_cnt != '0);
        end
        else if (state_reg == ST_PCT_GO)
        begin
            div_req.start    = 1'b1;
            div_req.dividend = num_mag_reg;
            div_req.divisor  = den_mag_reg;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                    state_next = (pop_job.valid_cnt == '0) ? ST_DONE : ST_AVG;
            end
            ST_AVG:
            begin
                if (div_rsp.done)
                    state_next = calib ? ST_DONE : ST_MUL;
            end
            ST_MUL:    state_next = ST_PCT_GO;
            ST_PCT_GO: state_next = ST_PCT;
            ST_PCT:
            begin
                if (div_rsp.done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Working registers of the current window.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            job_reg  <= pop_job;
            none_reg <= (pop_job.valid_cnt == '0);
            avg_reg  <= -AVG_W'(1);
            pct_reg  <= -PCT_W'(1);
        end
        if ((state_reg == ST_AVG) && div_rsp.done)
        begin
            avg_reg <= $signed({1'b0, div_rsp.quotient[LEVEL_W-1:0]});
            pct_reg <= '0;
        end
        if (state_reg == ST_MUL)
        begin
            neg_reg     <= prod[19] ^ den[AVG_W-1];
            num_mag_reg <= prod[19] ? DIV_N_W'(-prod) : prod[DIV_N_W-1:0];
            den_mag_reg <= den[AVG_W-1] ? DIV_D_W'(-den) : den[DIV_D_W-1:0];
        end
        if ((state_reg == ST_PCT) && div_rsp.done)
        begin
            // Negative quotients saturate to zero, large ones to one hundred.
            if (neg_reg)
                pct_reg <= '0;
            else if (div_rsp.quotient > DIV_N_W'(PCT_MAX))
                pct_reg <= $signed({1'b0, PCT_MAX});
            else
                pct_reg <= $signed({1'b0, div_rsp.quotient[6:0]});
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_avg_reg     <= avg_reg;
            out_pct_reg     <= pct_reg;
            out_off_cnt_reg <= job_reg.off_cnt;
            out_off_sum_reg <= job_reg.off_sum;
            out_low_reg     <= (pct_reg < $signed({1'b0, job_reg.min_pct}));
            out_none_reg    <= none_reg;
            out_calib_reg   <= calib;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (result_out.ready)
            out_valid_reg <= 1'b0;
    end

    assign result_out.valid          = out_valid_reg;
    assign result_out.average        = out_avg_reg;
    assign result_out.percent        = out_pct_reg;
    assign result_out.offscale_count = out_off_cnt_reg;
    assign result_out.offscale_sum   = out_off_sum_reg;
    assign result_out.low_moisture   = out_low_reg;
    assign result_out.no_valid       = out_none_reg;
    assign result_out.calib_error    = out_calib_reg;

endmodule

@@ rtl/moisture_window_averager.sv @@
// ----------------------------------------------------------------------------
// moisture_window_averager
// Windowed average of moisture samples with off-scale rejection and a
// calibrated percentage.
// ----------------------------------------------------------------------------
// Throughput: one sample item per cycle; a two-entry job queue holds finished
// windows while the back is busy, and samples stall only when it is full.
// Result: after the last sample of a window the back runs two 19-step divider
// passes (average, then percentage), only the average pass with equal
// calibration levels and none when no sample is valid.
// Reset: registers return to defaults, accumulators clear, queue and result empty.
module moisture_window_averager
    import mwa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    mwa_sample_if.sink            sample_in,
    mwa_result_if.source          result_out
);

    logic push_valid;
    logic push_ready;
    job_t push_job;
    logic pop_valid;
    logic pop_ready;
    job_t pop_job;

    // Accumulation and classification.
    mwa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_in  (sample_in),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    // Finished windows waiting for the back.
    mwa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    // Division, mapping and the result register.
    mwa_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job),
        .result_out (result_out)
    );

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the moisture window averager. Sample items are
// sent with random gaps through a series of calibration settings, and every
// window result is checked field by field against a behavioral prediction
// of the window sums, the average and the percentage.
// ----------------------------------------------------------------------------
module tb_top;
    import mwa_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 64;
    localparam int STALL_LIMIT   = 2000;
    localparam int MIN_SAMPLES   = 1600;
    localparam int SAMPLE_MAX    = (1 << SAMPLE_W) - 1;

    // Kind of content that the sender puts into one window.
    typedef enum {MIX_WINDOW, OFFSCALE_WINDOW, INSCALE_WINDOW} window_flavor_t;

    // One window result as seen on the result channel.
    typedef struct {
        logic signed [AVG_W-1:0] average;
        logic signed [PCT_W-1:0] percent;
        logic [OFFCNT_W-1:0]     offscale_count;
        logic [SUM_W-1:0]        offscale_sum;
        logic                    low_moisture;
        logic                    no_valid;
        logic                    calib_error;
    } window_result_t;

    // Tracks the calibration and the open window, and holds the results
    // that finished windows are due to produce.
    class window_scoreboard;
        logic [LEVEL_W-1:0]  dry;
        logic [LEVEL_W-1:0]  wet;
        logic [LEVEL_W-1:0]  high_margin;
        logic [LEVEL_W-1:0]  low_margin;
        logic [MINPCT_W-1:0] min_pct;
        int                  good_sum;
        int                  off_sum;
        int                  off_cnt;
        int                  position;
        window_result_t      pending[$];
        int                  mismatches;

        function new();
            dry         = DRY_RESET;
            wet         = WET_RESET;
            high_margin = HIGH_RESET;
            low_margin  = LOW_RESET;
            min_pct     = MINPCT_RESET;
            mismatches  = 0;
            clear_window();
        endfunction

        function void clear_window();
            good_sum = 0;
            off_sum  = 0;
            off_cnt  = 0;
            position = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_DRY_LEVEL:   dry = value;
                REG_WET_LEVEL:   wet = value;
                REG_HIGH_MARGIN: high_margin = value;
                REG_LOW_MARGIN:  low_margin = value;
                REG_MIN_PERCENT: min_pct = value[MINPCT_W-1:0];
                default: ;
            endcase
        endfunction

        // Accumulates one accepted sample item and closes the window on its
        // last sample.
        function void take_sample(logic [SAMPLE_W-1:0] raw);
            int             s;
            int             d;
            int             w;
            int             good_cnt;
            int             avg;
            int             pct;
            window_result_t r;
            s = raw & SAMPLE_MASK;
            d = dry;
            w = wet;
            if (s > d + int'(high_margin) || s < w - int'(low_margin))
            begin
                off_cnt++;
                off_sum += s;
            end
            else if (s < w)
                good_sum += w;
            else if (s > d)
                good_sum += d;
            else
                good_sum += s;

            position++;
            if (position < WINDOW)
                return;

            good_cnt = position - off_cnt;
            if (good_cnt == 0)
            begin
                avg = -1;
                pct = -1;
            end
            else
            begin
                avg = good_sum / good_cnt;
                if (d == w)
                    pct = 0;
                else
                begin
                    // Integer division truncates toward zero, then saturate.
                    pct = ((avg - d) * 100) / (w - d);
                    if (pct < 0)
                        pct = 0;
                    if (pct > 100)
                        pct = 100;
                end
            end
            r.average        = AVG_W'(avg);
            r.percent        = PCT_W'(pct);
            r.offscale_count = OFFCNT_W'(off_cnt);
            r.offscale_sum   = SUM_W'(off_sum);
            r.low_moisture   = pct < int'(min_pct);
            r.no_valid       = good_cnt == 0;
            r.calib_error    = d == w;
            pending.push_back(r);
            clear_window();
        endfunction

        function void compare(string field, logic signed [31:0] want_v,
                              logic signed [31:0] got_v);
            if (want_v !== got_v)
            begin
                mismatches++;
                $display("%0t: %s expected %0d, got %0d", $time, field, want_v, got_v);
            end
        endfunction

        // Compares one accepted result item with the oldest pending window.
        function void check_window(window_result_t got);
            window_result_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                $display("%0t: result expected none, got average %0d", $time, got.average);
                return;
            end
            want = pending.pop_front();
            compare("average", want.average, got.average);
            compare("percent", want.percent, got.percent);
            compare("offscale_count", want.offscale_count, got.offscale_count);
            compare("offscale_sum", want.offscale_sum, got.offscale_sum);
            compare("low_moisture", want.low_moisture, got.low_moisture);
            compare("no_valid", want.no_valid, got.no_valid);
            compare("calib_error", want.calib_error, got.calib_error);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    mwa_sample_if sample_ch();
    mwa_result_if result_ch();

    window_scoreboard sb = new();
    window_flavor_t   window_flavor = MIX_WINDOW;
    int               sent_total = 0;
    int               idle_cycles = 0;
    bit               result_fast = 1'b0;

    // Calibration settings run in order: dry, wet, high margin, low margin,
    // minimum percent.
    int directed_cfg[6][5] = '{
        '{2000, 2000, 300, 300, 50},
        '{1000, 3000, 200, 200, 0},
        '{4095, 0, 4095, 4095, 100},
        '{0, 0, 0, 0, 100},
        '{4095, 4095, 0, 4095, 1},
        '{0, 4095, 0, 0, 100}
    };

    moisture_window_averager u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_in  (sample_ch),
        .result_out (result_ch)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Feed every accepted sample item to the prediction.
    always @(posedge clk)
    begin : sample_monitor
        if (rst_n && sample_ch.valid && sample_ch.ready)
            sb.take_sample(sample_ch.sample);
    end

    // Check every accepted result item.
    always @(posedge clk)
    begin : result_monitor
        window_result_t got;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.average        = result_ch.average;
            got.percent        = result_ch.percent;
            got.offscale_count = result_ch.offscale_count;
            got.offscale_sum   = result_ch.offscale_sum;
            got.low_moisture   = result_ch.low_moisture;
            got.no_valid       = result_ch.no_valid;
            got.calib_error    = result_ch.calib_error;
            sb.check_window(got);
        end
    end

    // End the run when neither channel moves for too long.
    always @(posedge clk)
    begin : watchdog
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result receiver: random stalls, with stretches of none.
    initial
    begin : result_receiver
        int stall;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 3) == 0)
                result_fast = !result_fast;
            stall = result_fast ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
        end
    end

    function automatic logic [SAMPLE_W-1:0] to_sample(int v);
        if (v < 0)
            return '0;
        if (v > SAMPLE_MAX)
            return SAMPLE_W'(SAMPLE_MAX);
        return SAMPLE_W'(v);
    endfunction

    // Picks a sample value that fits the window's flavor under the current
    // calibration, falling back to any value where none fits.
    function automatic logic [SAMPLE_W-1:0] draw_sample(window_flavor_t flavor);
        int top;
        int bottom;
        int in_lo;
        int in_hi;
        int pick;
        int corners[8];
        top    = int'(sb.dry) + int'(sb.high_margin);
        bottom = int'(sb.wet) - int'(sb.low_margin);
        in_lo  = bottom < 0 ? 0 : bottom;
        in_hi  = top > SAMPLE_MAX ? SAMPLE_MAX : top;
        case (flavor)
            OFFSCALE_WINDOW:
            begin
                if (top < SAMPLE_MAX && (bottom <= 0 || $urandom_range(0, 1) == 0))
                    return to_sample($urandom_range(top + 1, SAMPLE_MAX));
                if (bottom > 0)
                    return to_sample($urandom_range(0, bottom - 1));
                return to_sample($urandom_range(0, SAMPLE_MAX));
            end
            INSCALE_WINDOW:
            begin
                if (in_lo <= in_hi)
                    return to_sample($urandom_range(in_lo, in_hi));
                return to_sample($urandom_range(0, SAMPLE_MAX));
            end
            default:
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    return to_sample($urandom_range(0, SAMPLE_MAX));
                if (pick == 1)
                begin
                    // Threshold and range edges.
                    corners = '{0, SAMPLE_MAX, sb.dry, sb.wet, top, top + 1,
                                bottom, bottom - 1};
                    return to_sample(corners[$urandom_range(0, 7)]);
                end
                if (pick < 4)
                    return draw_sample(OFFSCALE_WINDOW);
                return draw_sample(INSCALE_WINDOW);
            end
        endcase
    endfunction

    // Sends one sample item after an idle gap and waits for its acceptance.
    task automatic send_sample(input logic [SAMPLE_W-1:0] value, input int gap);
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= value;
        do @(posedge clk); while (!sample_ch.ready);
        sent_total++;
    endtask

    // Sends a run of samples; each new window gets its own flavor.
    task automatic send_samples(input int count, input bit burst);
        int pick;
        repeat (count)
        begin
            if (sent_total % WINDOW == 0)
            begin
                pick = $urandom_range(0, 9);
                window_flavor = pick == 0 ? OFFSCALE_WINDOW :
                                pick == 1 ? INSCALE_WINDOW : MIX_WINDOW;
            end
            send_sample(draw_sample(window_flavor), burst ? 0 : $urandom_range(0, 7));
        end
    endtask

    // Stops sending until every pending window has reported and the back end
    // has had time to finish.
    task automatic wait_until_idle();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all five calibration registers, one per cycle.
    task automatic write_config(input int d, input int w, input int h, input int l,
                                input int m);
        logic [CFG_DATA_W-1:0] vals[5];
        logic [CFG_IDX_W-1:0]  idxs[5];
        vals = '{CFG_DATA_W'(d), CFG_DATA_W'(w), CFG_DATA_W'(h), CFG_DATA_W'(l),
                 CFG_DATA_W'(m)};
        idxs = '{REG_DRY_LEVEL, REG_WET_LEVEL, REG_HIGH_MARGIN, REG_LOW_MARGIN,
                 REG_MIN_PERCENT};
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idxs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            sb.write_reg(idxs[i], vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [SAMPLE_W-1:0] corner_samples[$];
        int                  d;
        int                  w;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = REG_DRY_LEVEL;
        cfg_data         = '0;
        sample_ch.valid  = 1'b0;
        sample_ch.sample = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes, bit patterns and the default thresholds.
        corner_samples = {12'd0, 12'd4095, 12'd2100, 12'd1150, 12'd2600, 12'd2601,
                          12'd2099, 12'd2101, 12'd1149, 12'd1151, 12'd1, 12'd4094,
                          12'haaa, 12'h555, 12'h800, 12'h7ff, 12'd3000, 12'd0};
        foreach (corner_samples[k])
            send_sample(corner_samples[k], k % 4 == 3 ? 1 : 0);
        send_samples($urandom_range(60, 150), 1'b0);

        // Equal, inverted and extreme calibrations.
        foreach (directed_cfg[p])
        begin
            wait_until_idle();
            write_config(directed_cfg[p][0], directed_cfg[p][1], directed_cfg[p][2],
                         directed_cfg[p][3], directed_cfg[p][4]);
            send_samples($urandom_range(30, 200), $urandom_range(0, 2) == 0);
        end

        // Random calibrations; phases often end partway through a window.
        while (sent_total < MIN_SAMPLES)
        begin
            wait_until_idle();
            d = $urandom_range(0, SAMPLE_MAX);
            w = $urandom_range(0, 5) == 0 ? d : $urandom_range(0, SAMPLE_MAX);
            write_config(d, w,
                         $urandom_range(0, 3) == 0 ? $urandom_range(0, 4095)
                                                   : $urandom_range(0, 400),
                         $urandom_range(0, 3) == 0 ? $urandom_range(0, 4095)
                                                   : $urandom_range(0, 400),
                         $urandom_range(0, 100));
            send_samples($urandom_range(30, 200), $urandom_range(0, 2) == 0);
        end

        wait_until_idle();
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/mwa_pkg.sv
rtl/mwa_if.sv
rtl/mwa_front.sv
rtl/mwa_queue.sv
rtl/mwa_div.sv
rtl/mwa_back.sv
rtl/moisture_window_averager.sv
dv/tb_top.sv
